// File: src/tpk_pkg.sv
// ----------------------------------------------------------------------------
// tpk_pkg
// Shared constants, types and arithmetic helpers of the thin-plate kernel
// entry pipeline.
// ----------------------------------------------------------------------------
package tpk_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 27;
    localparam int WORK_FRAC       = 30;

    localparam int COORD_W = COORD_FRAC_BITS + 1;
    localparam int ENTRY_W = 32;
    localparam int CW      = WORK_FRAC + 1;
    localparam int PW      = WORK_FRAC + 3;
    localparam int WW      = WORK_FRAC + 5;
    localparam int R2_W    = 2 * WORK_FRAC + 2;
    localparam int RT_W    = WORK_FRAC + 1;
    localparam int K_W     = $clog2(R2_W);
    localparam int A_W     = WORK_FRAC + 3;
    localparam int CP_W    = WW + A_W;
    localparam int ACC_W   = 48;
    localparam int NSQ     = R2_W / 2;
    localparam int NST     = WORK_FRAC + 2;
    localparam int XL_LAT  = NST + 4;

    localparam int LN2_Q26 = 46516320;
    localparam int LN_SH   = 27;
    localparam int LN_W    = 27;
    localparam int LNR_W   = 40;
    localparam int LO_W    = 20;

    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;
    localparam logic [CW-1:0]      HALF_W    = CW'(1) << (WORK_FRAC - 1);
    localparam logic signed [PW-1:0] ONE_P   = signed'(PW'(1) << WORK_FRAC);

    typedef struct packed {
        logic [R2_W-1:0] v;
        logic [R2_W-1:0] res;
    } t_sqrt;

    typedef struct packed {
        logic [WORK_FRAC:0] m;
        logic               b;
    } t_sq;

    function automatic logic [CW-1:0] f_coord(input logic [COORD_W-1:0] raw);
        logic [COORD_W-1:0] c;
        c = (raw > COORD_ONE) ? COORD_ONE : raw;
        return CW'(c) << (WORK_FRAC - COORD_FRAC_BITS);
    endfunction

    function automatic logic [CW-1:0] f_absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic signed [63:0] f_rndw(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
    endfunction

    function automatic logic [K_W-1:0] f_lead(input logic [R2_W-1:0] v);
        logic [K_W-1:0] k;
        k = '0;
        for (int b = 0; b < R2_W; b++) begin
            if (v[b]) k = K_W'(b);
        end
        return k;
    endfunction

    function automatic logic [WORK_FRAC:0] f_norm(input logic [R2_W-1:0] v,
                                                  input logic [K_W-1:0] k);
        logic [R2_W-1:0] t;
        if (k >= WORK_FRAC) t = v >> (k - WORK_FRAC);
        else t = v << (WORK_FRAC - k);
        return t[WORK_FRAC:0];
    endfunction

    function automatic t_sqrt f_sqrt_step(input t_sqrt a, input int i);
        t_sqrt           o;
        logic [R2_W:0]   t;
        logic [R2_W-1:0] bt;
        bt = R2_W'(1) << (R2_W - 2 - 2 * i);
        t  = {1'b0, a.res} + {1'b0, bt};
        o  = a;
        if ({1'b0, a.v} >= t) begin
            o.v   = a.v - t[R2_W-1:0];
            o.res = (a.res >> 1) + bt;
        end else begin
            o.res = a.res >> 1;
        end
        return o;
    endfunction

    function automatic t_sq f_sq_step(input logic [WORK_FRAC:0] m);
        t_sq                        o;
        logic [R2_W-1:0]            p;
        logic [R2_W-WORK_FRAC-1:0]  q;
        p = m * m;
        q = p[R2_W-1:WORK_FRAC];
        if (q[WORK_FRAC+1]) begin
            o.m = q[WORK_FRAC+1:1];
            o.b = 1'b1;
        end else begin
            o.m = q[WORK_FRAC:0];
            o.b = 1'b0;
        end
        return o;
    endfunction

    // elaboration-time evaluation for the anchor-to-anchor constants
    function automatic logic signed [63:0] f_xlogx(input logic [63:0] r2);
        logic [63:0]        m;
        logic [63:0]        v;
        logic [63:0]        rs;
        logic [63:0]        bt;
        logic [63:0]        fr;
        logic signed [63:0] l2;
        logic signed [63:0] ln;
        logic signed [63:0] p;
        int                 k;
        k  = 0;
        fr = '0;
        v  = r2;
        rs = '0;
        for (int b = 0; b < 64; b++) begin
            if (r2[b]) k = b;
        end
        if (k >= WORK_FRAC) m = r2 >> (k - WORK_FRAC);
        else m = r2 << (WORK_FRAC - k);
        for (int i = 0; i < WORK_FRAC; i++) begin
            m = (m * m) >> WORK_FRAC;
            if (m >= (64'd2 << WORK_FRAC)) begin
                m = m >> 1;
                fr[WORK_FRAC-1-i] = 1'b1;
            end
        end
        for (int i = 0; i < 32; i++) begin
            bt = 64'd1 << (62 - 2 * i);
            if (v >= rs + bt) begin
                v  = v - (rs + bt);
                rs = (rs >> 1) + bt;
            end else begin
                rs = rs >> 1;
            end
        end
        l2 = (64'(k - 2 * WORK_FRAC) <<< WORK_FRAC) + signed'(fr);
        ln = (l2 * 64'(LN2_Q26) + (64'sd1 <<< (LN_SH - 1))) >>> LN_SH;
        p  = signed'(rs) * ln;
        if (r2 == '0) return '0;
        return (p + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
    endfunction

    localparam logic signed [A_W-1:0] A_HALF =
        A_W'(f_xlogx(64'd1 << (2 * WORK_FRAC - 2)));
    localparam logic signed [A_W-1:0] A_DIAG =
        A_W'(f_xlogx(64'd1 << (2 * WORK_FRAC - 1)));

endpackage

// File: src/tpk_in_if.sv
// ----------------------------------------------------------------------------
// tpk_in_if
// Point-pair channel: valid/ready handshake with four coordinates.
// ----------------------------------------------------------------------------
interface tpk_in_if;
    import tpk_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] xi;
    logic [COORD_W-1:0] yi;
    logic [COORD_W-1:0] xj;
    logic [COORD_W-1:0] yj;

    modport source (output valid, output xi, output yi, output xj, output yj,
                    input ready);
    modport sink   (input valid, input xi, input yi, input xj, input yj,
                    output ready);
endinterface

// File: src/tpk_out_if.sv
// ----------------------------------------------------------------------------
// tpk_out_if
// Kernel entry channel: valid/ready handshake with entry and clip flag.
// ----------------------------------------------------------------------------
interface tpk_out_if;
    import tpk_pkg::*;

    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] entry;
    logic               saturated;

    modport source (output valid, output entry, output saturated, input ready);
    modport sink   (input valid, input entry, input saturated, output ready);
endinterface

// File: src/thin_plate_kernel_entry_core.sv
// ----------------------------------------------------------------------------
// thin_plate_kernel_entry_core
// Constrained thin-plate spline covariance entry for one point pair.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries a point pair (xi, yi, xj, yj), unsigned Q1.16, values above
//         1.0 are clipped to 1.0. A transaction completes when valid and
//         ready are both high at a rising edge of i_clk.
//   o_out carries the entry (signed Q4.27, clipped) and the saturated flag.
//   Throughput: one pair per cycle while o_out is not stalled. A pair passes
//   through 44 register stages from the accepting edge to o_out.valid: 4
//   for coordinates, distances, squares and weights, 36 in the r*ln(r)
//   pipeline (32 for root digits and log2 squarings, 4 for the ln 2
//   scaling and product), and 4 for the weighted products, the sums and
//   the output clip. Seven r*ln(r) pipelines run side by side, one for
//   each distance. When o_out is stalled with a result waiting, the whole
//   pipeline holds and i_in.ready drops; nothing is lost or repeated. The
//   pipeline also advances whenever its last stage is empty.
//   Reset (i_rst_n low, synchronous) clears all valid bits; no results are
//   presented until new pairs arrive.
// ----------------------------------------------------------------------------
module thin_plate_kernel_entry_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpk_in_if.sink    i_in,
    tpk_out_if.source o_out
);
    import tpk_pkg::*;

    localparam int NV  = XL_LAT + 8;
    localparam int DL  = XL_LAT - 1;
    localparam int OSH = (OUT_FRAC_BITS >= WORK_FRAC) ? (OUT_FRAC_BITS - WORK_FRAC)
                                                      : (WORK_FRAC - OUT_FRAC_BITS);
    localparam logic signed [63:0] E_MAX = 64'sd2147483647;
    localparam logic signed [63:0] E_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [5:0][PW-1:0] p;
        logic [ACC_W-1:0]   ct;
    } t_side;

    logic            w_en;
    logic [NV-1:0]   r_vld;

    logic [CW-1:0]            r1_c  [4];
    logic [CW-1:0]            r2_d  [14];
    logic signed [PW-1:0]     r2_p  [6];
    logic [R2_W-1:0]          r3_sq [14];
    logic signed [2*PW-1:0]   r3_pp [6];
    logic signed [PW-1:0]     r3_p  [6];
    logic [R2_W-1:0]          r4_r2 [7];
    logic signed [WW-1:0]     r4_w  [3];
    logic signed [PW-1:0]     r4_p  [6];
    logic signed [CP_W-1:0]   r5_cp [3];
    logic signed [PW-1:0]     r5_p  [6];
    t_side                    r_dl  [DL];
    logic signed [A_W-1:0]    w_a   [7];
    logic signed [ACC_W-1:0]  r6_t  [6];
    logic signed [ACC_W-1:0]  r6_a0;
    logic signed [ACC_W-1:0]  r6_ct;
    logic signed [ACC_W-1:0]  r7_sa;
    logic signed [ACC_W-1:0]  r7_sb;
    logic signed [ACC_W-1:0]  r8_acc;
    logic [ENTRY_W-1:0]       r_entry;
    logic                     r_sat;

    logic [CW-1:0]            n_c   [4];
    logic [CW-1:0]            n_d   [14];
    logic signed [PW-1:0]     n_p   [6];
    logic [R2_W-1:0]          n_sq  [14];
    logic signed [2*PW-1:0]   n_pp  [6];
    logic [R2_W-1:0]          n_r2  [7];
    logic signed [WW-1:0]     n_w   [3];
    logic signed [CP_W-1:0]   n_cp  [3];
    t_side                    n_dl;
    logic signed [PW+A_W-1:0] n_pr  [6];
    logic signed [ACC_W-1:0]  n_t   [6];
    logic signed [63:0]       n_acc;
    logic signed [63:0]       n_e;
    logic [ENTRY_W-1:0]       n_entry;
    logic                     n_sat;

    assign w_en        = !r_vld[NV-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[NV-1];
    assign o_out.entry = r_entry;
    assign o_out.saturated = r_sat;

    always_comb begin
        n_c[0] = f_coord(i_in.xi);
        n_c[1] = f_coord(i_in.yi);
        n_c[2] = f_coord(i_in.xj);
        n_c[3] = f_coord(i_in.yj);

        n_d[0]  = f_absd(r1_c[0], r1_c[2]);
        n_d[1]  = f_absd(r1_c[1], r1_c[3]);
        n_d[2]  = r1_c[0];
        n_d[3]  = r1_c[1];
        n_d[4]  = f_absd(r1_c[0], HALF_W);
        n_d[5]  = r1_c[1];
        n_d[6]  = r1_c[0];
        n_d[7]  = f_absd(r1_c[1], HALF_W);
        n_d[8]  = r1_c[2];
        n_d[9]  = r1_c[3];
        n_d[10] = f_absd(r1_c[2], HALF_W);
        n_d[11] = r1_c[3];
        n_d[12] = r1_c[2];
        n_d[13] = f_absd(r1_c[3], HALF_W);

        for (int q = 0; q < 2; q++) begin
            n_p[3*q+1] = signed'(PW'(r1_c[2*q]) << 1);
            n_p[3*q+2] = signed'(PW'(r1_c[2*q+1]) << 1);
            n_p[3*q]   = ONE_P - n_p[3*q+1] - n_p[3*q+2];
        end

        for (int l = 0; l < 14; l++) n_sq[l] = r2_d[l] * r2_d[l];
        n_pp[0] = r2_p[0] * r2_p[4];
        n_pp[1] = r2_p[1] * r2_p[3];
        n_pp[2] = r2_p[0] * r2_p[5];
        n_pp[3] = r2_p[2] * r2_p[3];
        n_pp[4] = r2_p[1] * r2_p[5];
        n_pp[5] = r2_p[2] * r2_p[4];

        for (int l = 0; l < 7; l++) n_r2[l] = r3_sq[2*l] + r3_sq[2*l+1];
        for (int c = 0; c < 3; c++) begin
            n_w[c] = WW'(f_rndw(64'(r3_pp[2*c])) + f_rndw(64'(r3_pp[2*c+1])));
        end

        n_cp[0] = r4_w[0] * A_HALF;
        n_cp[1] = r4_w[1] * A_HALF;
        n_cp[2] = r4_w[2] * A_DIAG;

        for (int l = 0; l < 6; l++) n_dl.p[l] = r5_p[l];
        n_dl.ct = ACC_W'(f_rndw(64'(r5_cp[0])) + f_rndw(64'(r5_cp[1]))
                         + f_rndw(64'(r5_cp[2])));

        for (int l = 1; l < 7; l++) begin
            n_pr[l-1] = signed'(r_dl[DL-1].p[(l+2)%6]) * w_a[l];
            n_t[l-1]  = ACC_W'(f_rndw(64'(n_pr[l-1])));
        end

        n_acc = 64'(r8_acc);
        n_sat = 1'b0;
        if (OUT_FRAC_BITS >= WORK_FRAC) begin
            if (n_acc > (E_MAX >>> OSH)) begin
                n_e   = E_MAX;
                n_sat = 1'b1;
            end else if (n_acc < -(64'sd1 <<< (31 - OSH))) begin
                n_e   = E_MIN;
                n_sat = 1'b1;
            end else begin
                n_e = n_acc <<< OSH;
            end
        end else begin
            n_e = (n_acc + (64'sd1 <<< (OSH - 1))) >>> OSH;
            if (n_e > E_MAX) begin
                n_e   = E_MAX;
                n_sat = 1'b1;
            end else if (n_e < E_MIN) begin
                n_e   = E_MIN;
                n_sat = 1'b1;
            end
        end
        n_entry = n_e[ENTRY_W-1:0];
    end

    for (genvar g = 0; g < 7; g++) begin : g_lane
        tpk_xlogx u_xlogx (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_r2  (r4_r2[g]),
            .o_a   (w_a[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_c  <= n_c;
            r2_d  <= n_d;
            r2_p  <= n_p;
            r3_sq <= n_sq;
            r3_pp <= n_pp;
            r3_p  <= r2_p;
            r4_r2 <= n_r2;
            r4_w  <= n_w;
            r4_p  <= r3_p;
            r5_cp <= n_cp;
            r5_p  <= r4_p;
            r_dl[0] <= n_dl;
            for (int i = 1; i < DL; i++) r_dl[i] <= r_dl[i-1];
            r6_t  <= n_t;
            r6_a0 <= ACC_W'(w_a[0]);
            r6_ct <= signed'(r_dl[DL-1].ct);
            r7_sa <= r6_a0 + r6_ct - r6_t[0] - r6_t[1] - r6_t[2];
            r7_sb <= r6_t[3] + r6_t[4] + r6_t[5];
            r8_acc <= r7_sa - r7_sb;
            r_entry <= n_entry;
            r_sat   <= n_sat;
        end
    end

endmodule

// File: src/tpk_xlogx.sv
// ----------------------------------------------------------------------------
// tpk_xlogx
// Pipelined r*ln(r) from a squared distance: leading-one normalize, at most one
// log2 squaring step and at most one root digit per stage, then ln 2 scaling and the root product.
// ----------------------------------------------------------------------------
module tpk_xlogx (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tpk_pkg::R2_W-1:0]       i_r2,
    output logic signed [tpk_pkg::A_W-1:0] o_a
);
    import tpk_pkg::*;

    localparam logic signed [K_W+1:0]  KD_OFF = (K_W + 2)'(2 * WORK_FRAC);
    localparam logic signed [LN_W-1:0] LN2_S  = LN_W'(LN2_Q26);
    localparam logic [LN_W-2:0]        LN2_U  = (LN_W - 1)'(LN2_Q26);

    logic [R2_W-1:0]      r_r2;
    logic [R2_W-1:0]      r_v    [NST];
    logic [R2_W-1:0]      r_res  [NST];
    logic [K_W-1:0]       r_k    [NST];
    logic                 r_z    [NST];
    logic [WORK_FRAC:0]   r_m    [NST];
    logic [WORK_FRAC-1:0] r_frac [NST];
    logic [R2_W-1:0]      n_v    [NST];
    logic [R2_W-1:0]      n_res  [NST];
    logic [K_W-1:0]       n_k    [NST];
    logic                 n_z    [NST];
    logic [WORK_FRAC:0]   n_m    [NST];
    logic [WORK_FRAC-1:0] n_frac [NST];

    logic signed [K_W+LN_W+1:0]     r_pk;
    logic [WORK_FRAC+LN_W-2:0]      r_pf;
    logic [RT_W-1:0]                r_ra;
    logic                           r_za;
    logic signed [LNR_W-1:0]        r_lnr;
    logic [RT_W-1:0]                r_rb;
    logic                           r_zb;
    logic signed [RT_W+LNR_W-LO_W:0] r_ph;
    logic [RT_W+LO_W-1:0]           r_pl;
    logic                           r_zc;
    logic signed [A_W-1:0]          r_a;

    logic signed [K_W+1:0]          n_kd;
    logic signed [K_W+LN_W+1:0]     n_pk;
    logic [WORK_FRAC+LN_W-2:0]      n_pf;
    logic signed [63:0]             n_ls;
    logic signed [LNR_W-1:0]        n_lnr;
    logic signed [RT_W+LNR_W-LO_W:0] n_ph;
    logic [RT_W+LO_W-1:0]           n_pl;
    logic signed [63:0]             n_sum;
    logic signed [A_W-1:0]          n_a;

    always_comb begin
        t_sqrt sq;
        t_sq   ms;
        sq        = f_sqrt_step('{v: i_r2, res: '0}, 0);
        n_v[0]    = sq.v;
        n_res[0]  = sq.res;
        n_k[0]    = f_lead(i_r2);
        n_z[0]    = (i_r2 == '0);
        n_m[0]    = '0;
        n_frac[0] = '0;

        sq        = f_sqrt_step('{v: r_v[0], res: r_res[0]}, 1);
        n_v[1]    = sq.v;
        n_res[1]  = sq.res;
        n_k[1]    = r_k[0];
        n_z[1]    = r_z[0];
        n_m[1]    = f_norm(r_r2, r_k[0]);
        n_frac[1] = '0;

        for (int s = 2; s < NST; s++) begin
            if (s < NSQ) sq = f_sqrt_step('{v: r_v[s-1], res: r_res[s-1]}, s);
            else sq = '{v: r_v[s-1], res: r_res[s-1]};
            ms        = f_sq_step(r_m[s-1]);
            n_v[s]    = sq.v;
            n_res[s]  = sq.res;
            n_k[s]    = r_k[s-1];
            n_z[s]    = r_z[s-1];
            n_m[s]    = ms.m;
            n_frac[s] = r_frac[s-1];
            n_frac[s][WORK_FRAC+1-s] = ms.b;
        end
    end

    always_comb begin
        n_kd  = signed'({2'b00, r_k[NST-1]}) - KD_OFF;
        n_pk  = n_kd * LN2_S;
        n_pf  = r_frac[NST-1] * LN2_U;
        n_ls  = (64'(r_pk) <<< WORK_FRAC) + signed'(64'(r_pf));
        n_lnr = LNR_W'((n_ls + (64'sd1 <<< (LN_SH - 1))) >>> LN_SH);
        n_ph  = signed'({1'b0, r_rb}) * signed'(r_lnr[LNR_W-1:LO_W]);
        n_pl  = r_rb * r_lnr[LO_W-1:0];
        n_sum = (64'(r_ph) <<< LO_W) + signed'(64'(r_pl));
        n_a   = r_zc ? '0 : A_W'(f_rndw(n_sum));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2 <= i_r2;
            for (int s = 0; s < NST; s++) begin
                r_v[s]    <= n_v[s];
                r_res[s]  <= n_res[s];
                r_k[s]    <= n_k[s];
                r_z[s]    <= n_z[s];
                r_m[s]    <= n_m[s];
                r_frac[s] <= n_frac[s];
            end
            r_pk  <= n_pk;
            r_pf  <= n_pf;
            r_ra  <= r_res[NST-1][RT_W-1:0];
            r_za  <= r_z[NST-1];
            r_lnr <= n_lnr;
            r_rb  <= r_ra;
            r_zb  <= r_za;
            r_ph  <= n_ph;
            r_pl  <= n_pl;
            r_zc  <= r_zb;
            r_a   <= n_a;
        end
    end

    assign o_a = r_a;

endmodule
